[sv/xcpd_pkg.sv]
// ----------------------------------------------------------------------------
// xcpd_pkg: shared types and constants of the packet deframer
// Result kinds, configuration register indexes, reset values and the job
// descriptor that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package xcpd_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_BYTE  = 2'd0;
    localparam t_kind KIND_EMPTY = 2'd1;
    localparam t_kind KIND_ERROR = 2'd2;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_SYNC_BYTE  = 2'd0;
    localparam t_cfg_idx CFG_MAX_LENGTH = 2'd1;

    localparam logic [7:0] SYNC_BYTE_RESET  = 8'hAA;
    localparam logic [5:0] MAX_LENGTH_RESET = 6'd32;

    localparam int JOBQ_DEPTH = 2;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] command;
        logic [5:0] length;
    } t_job;

endpackage

[sv/xcpd_ram.sv]
// ----------------------------------------------------------------------------
// xcpd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module xcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/xcpd_front.sv]
// ----------------------------------------------------------------------------
// xcpd_front: frame parser
// Hunts for the sync byte, captures command and length, writes the payload
// into the store and turns the checksum byte into a job for the back end.
// ----------------------------------------------------------------------------
module xcpd_front #(
    parameter int MAX_PAYLOAD = 32,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  xcpd_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_push,
    output logic                o_full,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_store_busy,
    input  logic                i_job_full,
    output logic                o_job_push,
    output xcpd_pkg::t_job      o_job,
    output logic                o_ram_we,
    output logic [AW-1:0]       o_ram_waddr,
    output logic [7:0]          o_ram_wdata
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA,
        PH_CHECK
    } t_phase;

    localparam logic [6:0] PAYLOAD_CAP = 7'(MAX_PAYLOAD);

    t_phase     r_phase;
    logic [7:0] r_sync_byte;
    logic [5:0] r_max_length;
    logic [7:0] r_command;
    logic [5:0] r_length;
    logic [5:0] r_fill;
    logic [7:0] r_xor;

    logic [6:0] limit;
    logic [5:0] fill_inc;
    logic       accept;

    assign limit    = ({1'b0, r_max_length} > PAYLOAD_CAP) ? PAYLOAD_CAP
                                                           : {1'b0, r_max_length};
    assign fill_inc = r_fill + 6'd1;

    assign o_full = ((r_phase == PH_CHECK) && i_job_full) ||
                    ((r_phase == PH_DATA) && i_store_busy);
    assign accept = i_push && !o_full;

    assign o_ram_we    = accept && (r_phase == PH_DATA);
    assign o_ram_waddr = r_fill[AW-1:0];
    assign o_ram_wdata = i_rx_byte;

    assign o_job_push     = accept && (r_phase == PH_CHECK);
    assign o_job.command  = r_command;
    assign o_job.length   = r_length;
    assign o_job.kind     = (i_rx_byte != r_xor) ? xcpd_pkg::KIND_ERROR :
                            (r_length == 6'd0)   ? xcpd_pkg::KIND_EMPTY :
                                                   xcpd_pkg::KIND_BYTE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_sync_byte  <= xcpd_pkg::SYNC_BYTE_RESET;
            r_max_length <= xcpd_pkg::MAX_LENGTH_RESET;
            r_command    <= 8'd0;
            r_length     <= 6'd0;
            r_fill       <= 6'd0;
            r_xor        <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    xcpd_pkg::CFG_SYNC_BYTE:  r_sync_byte  <= i_cfg_wdata;
                    xcpd_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_wdata[5:0];
                    default: ;
                endcase
            end
            if (accept) begin
                unique case (r_phase)
                    PH_HUNT: begin
                        if (i_rx_byte == r_sync_byte) begin
                            r_xor   <= 8'd0;
                            r_phase <= PH_CMD;
                        end
                    end
                    PH_CMD: begin
                        r_command <= i_rx_byte;
                        r_xor     <= r_xor ^ i_rx_byte;
                        r_phase   <= PH_LEN;
                    end
                    PH_LEN: begin
                        r_xor    <= r_xor ^ i_rx_byte;
                        r_fill   <= 6'd0;
                        r_length <= i_rx_byte[5:0];
                        if (i_rx_byte == 8'd0) begin
                            r_phase <= PH_CHECK;
                        end else if (i_rx_byte > {1'b0, limit}) begin
                            r_phase <= PH_HUNT;
                        end else begin
                            r_phase <= PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        r_fill <= fill_inc;
                        r_xor  <= r_xor ^ i_rx_byte;
                        if (fill_inc >= r_length) begin
                            r_phase <= PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        r_phase <= PH_HUNT;
                    end
                    default: begin
                        r_phase <= PH_HUNT;
                    end
                endcase
            end
        end
    end

    // The payload store is only written while no earlier packet is draining.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> !i_store_busy)
        else $error("payload written while the store is still being read");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_fill < r_length))
        else $error("fill count has passed the frame length");

endmodule

[sv/xcpd_job_queue.sv]
// ----------------------------------------------------------------------------
// xcpd_job_queue: short queue of packet jobs
// Decouples the frame parser from the result sequencer.
// ----------------------------------------------------------------------------
module xcpd_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xcpd_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output xcpd_pkg::t_job  o_job
);

    localparam int PW = (xcpd_pkg::JOBQ_DEPTH > 1) ? $clog2(xcpd_pkg::JOBQ_DEPTH) : 1;
    localparam int CW = $clog2(xcpd_pkg::JOBQ_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(xcpd_pkg::JOBQ_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(xcpd_pkg::JOBQ_DEPTH - 1);

    xcpd_pkg::t_job r_slot [xcpd_pkg::JOBQ_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into a full queue");

endmodule

[sv/xcpd_back.sv]
// ----------------------------------------------------------------------------
// xcpd_back: result sequencer
// Turns each job into result words, reading stored payload bytes one by one
// into the output register.
// ----------------------------------------------------------------------------
module xcpd_back #(
    parameter int MAX_PAYLOAD = 32,
    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  xcpd_pkg::t_job      i_job,
    output logic                o_job_pop,
    output logic                o_busy,
    output logic                o_ram_re,
    output logic [AW-1:0]       o_ram_raddr,
    input  logic [7:0]          i_ram_rdata,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_command,
    output logic [5:0]          o_length,
    output logic [4:0]          o_position,
    output logic [7:0]          o_data,
    output logic                o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT
    } t_state;

    t_state     r_state;
    logic [7:0] r_command;
    logic [5:0] r_length;
    logic [5:0] r_idx;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [7:0] r_out_command;
    logic [5:0] r_out_length;
    logic [4:0] r_position;
    logic [7:0] r_data;
    logic       r_last;

    logic       out_free;
    logic       out_load;
    logic       idx_last;

    assign out_free  = !r_out_valid || i_pop;
    assign idx_last  = ((r_idx + 6'd1) == r_length);
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid &&
                       ((i_job.kind == xcpd_pkg::KIND_BYTE) || out_free);
    assign out_load  = ((r_state == S_IDLE) && o_job_pop &&
                        (i_job.kind != xcpd_pkg::KIND_BYTE)) ||
                       ((r_state == S_WAIT) && out_free);
    assign o_busy      = (r_state != S_IDLE);
    assign o_ram_re    = (r_state == S_READ);
    assign o_ram_raddr = r_idx[AW-1:0];

    assign o_empty    = !r_out_valid;
    assign o_kind     = r_kind;
    assign o_command  = r_out_command;
    assign o_length   = r_out_length;
    assign o_position = r_position;
    assign o_data     = r_data;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= 6'd0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        if (i_job.kind == xcpd_pkg::KIND_BYTE) begin
                            r_command <= i_job.command;
                            r_length  <= i_job.length;
                            r_idx     <= 6'd0;
                            r_state   <= S_READ;
                        end else begin
                            r_kind        <= i_job.kind;
                            r_out_command <= i_job.command;
                            r_out_length  <= i_job.length;
                            r_position    <= 5'd0;
                            r_data        <= 8'd0;
                            r_last        <= 1'b1;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (out_free) begin
                        r_kind        <= xcpd_pkg::KIND_BYTE;
                        r_out_command <= r_command;
                        r_out_length  <= r_length;
                        r_position    <= r_idx[4:0];
                        r_data        <= i_ram_rdata;
                        r_last        <= idx_last;
                        if (idx_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 6'd1;
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx < r_length))
        else $error("payload index has passed the packet length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> i_job_valid)
        else $error("job taken from an empty queue");

endmodule

[sv/xor_checked_packet_deframer_core.sv]
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer_core: sync / command / length / payload / XOR
// deframer. A parser front end feeds packet jobs through a short queue to a
// sequencer that emits one result word per payload byte, or one word for an
// empty packet or a checksum error.
//
//   channel   direction  handshake           fields
//   input     in         push / full         rx_byte
//   result    out        empty / pop         kind command length position
//                                            data last
//   config    in         i_cfg_we            i_cfg_idx i_cfg_wdata
//
// The parser takes an input byte whenever push is high and full is low.
// Each payload result passes the sequencer states S_READ and S_WAIT, due to the
// single registered RAM read port; empty and error results skip both states.
// Reset is synchronous and needs no clearing pass; the payload RAM is not reset.
// full is raised on a checksum byte while the job queue is full, and on a
// payload byte while an earlier job is still queued or being read out.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  xcpd_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_rx_byte,
    output logic                empty,
    input  logic                pop,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_command,
    output logic [5:0]          o_length,
    output logic [4:0]          o_position,
    output logic [7:0]          o_data,
    output logic                o_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic           job_push;
    xcpd_pkg::t_job job_in;
    logic           job_full;
    logic           job_pop;
    logic           job_valid;
    xcpd_pkg::t_job job_out;
    logic           back_busy;
    logic           store_busy;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;

    assign store_busy = back_busy || job_valid;

    xcpd_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .o_full       (full),
        .i_rx_byte    (i_rx_byte),
        .i_store_busy (store_busy),
        .i_job_full   (job_full),
        .o_job_push   (job_push),
        .o_job        (job_in),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata)
    );

    xcpd_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    xcpd_job_queue u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_job   (job_out)
    );

    xcpd_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_busy      (back_busy),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_kind      (o_kind),
        .o_command   (o_command),
        .o_length    (o_length),
        .o_position  (o_position),
        .o_data      (o_data),
        .o_last      (o_last)
    );

endmodule
